// File: src/ir_pulse_width_frame_decoder_defines.svh
// Assertion helpers for the IR frame decoder.
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH

// Checked at every clock edge outside reset.
`define IRPWFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define IRPWFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/ir_pwfd_pkg.sv
`default_nettype none

package ir_pwfd_pkg;

   localparam int unsigned TICK_W      = 16;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned INDEX_W     = 3;
   localparam int unsigned CSR_ADDR_W  = 8;
   localparam int unsigned BYTE_BITS   = 8;
   localparam int unsigned DATA_BYTES_DEFAULT = 8;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

   localparam logic [TICK_W-1:0] START_MIN_RST = 16'd17000;
   localparam logic [TICK_W-1:0] START_MAX_RST = 16'd20000;
   localparam logic [TICK_W-1:0] ONE_MIN_RST   = 16'd2000;
   localparam logic [TICK_W-1:0] ONE_MAX_RST   = 16'd3600;
   localparam logic [TICK_W-1:0] ZERO_MIN_RST  = 16'd800;
   localparam logic [TICK_W-1:0] ZERO_MAX_RST  = 16'd1800;
   localparam logic [TICK_W-1:0] SYNC_MIN_RST  = 16'd12000;
   localparam logic [TICK_W-1:0] SYNC_MAX_RST  = 16'd17000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_START_MIN = 8'd0,
      REG_START_MAX = 8'd1,
      REG_ONE_MIN   = 8'd2,
      REG_ONE_MAX   = 8'd3,
      REG_ZERO_MIN  = 8'd4,
      REG_ZERO_MAX  = 8'd5,
      REG_SYNC_MIN  = 8'd6,
      REG_SYNC_MAX  = 8'd7
   } reg_index_type;

   function automatic logic in_window(
      input logic [TICK_W-1:0] t,
      input logic [TICK_W-1:0] lo,
      input logic [TICK_W-1:0] hi
   );
      return (t >= lo) && (t <= hi);
   endfunction

endpackage

`default_nettype wire

// File: src/ir_pulse_width_frame_decoder.sv
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall  pulse_ticks
// rsp_      out        rsp_valid/rsp_stall  data_byte, byte_index, last_byte
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One interval per cycle unless stalled; the byte result is registered when
// the eighth interval of a byte is taken. The single output register sets the
// rate: input stalls only while a result waits and rsp_stall is high.
// Reset is synchronous; it loads the default windows and returns to idle.
// CSR writes are always ready; writes to an index above 7 are dropped.

`default_nettype none

`include "ir_pulse_width_frame_decoder_defines.svh"

module ir_pulse_width_frame_decoder
   import ir_pwfd_pkg::*;
#(
   parameter int unsigned DATA_BYTES = DATA_BYTES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [TICK_W-1:0]     req_pulse_ticks,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [BYTE_W-1:0]     rsp_data_byte,
   output      logic [INDEX_W-1:0]    rsp_byte_index,
   output      logic                  rsp_last_byte,

   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]     csr_wdata
);

   localparam int unsigned BIT_CNT_W = $clog2(BYTE_BITS);
   localparam int unsigned BYTE_CNT_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
   localparam int unsigned BYTE_EXT_W = (BYTE_CNT_W > INDEX_W) ? BYTE_CNT_W : INDEX_W;
   localparam logic [BIT_CNT_W-1:0]  BIT_LAST  = BIT_CNT_W'(BYTE_BITS - 1);
   localparam logic [BYTE_CNT_W-1:0] BYTE_LAST = BYTE_CNT_W'(DATA_BYTES - 1);

   logic [TICK_W-1:0] start_min_ff, start_max_ff, one_min_ff, one_max_ff;
   logic [TICK_W-1:0] zero_min_ff, zero_max_ff, sync_min_ff, sync_max_ff;

   logic                  frame_open_ff, frame_open_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [BYTE_CNT_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic [BYTE_W-1:0]     shift_ff, shift_in;
   logic                  sync_ff, sync_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     data_ff, data_in;
   logic [INDEX_W-1:0]    index_ff, index_in;
   logic                  last_ff, last_in;

   logic                  accept, start_hit, hit_one, hit_zero, hit_sync;
   logic                  byte_done, emit;
   logic [BYTE_EXT_W-1:0] byte_ext;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign start_hit = (req_pulse_ticks > start_min_ff) && (req_pulse_ticks < start_max_ff);
   assign hit_one   = in_window(req_pulse_ticks, one_min_ff, one_max_ff);
   assign hit_zero  = in_window(req_pulse_ticks, zero_min_ff, zero_max_ff);
   assign hit_sync  = in_window(req_pulse_ticks, sync_min_ff, sync_max_ff);

   assign byte_done = frame_open_ff && (bit_cnt_ff == BIT_LAST);
   assign emit      = accept & byte_done;
   assign byte_ext  = BYTE_EXT_W'(byte_cnt_ff);

   always_comb begin
      frame_open_in = frame_open_ff;
      bit_cnt_in    = bit_cnt_ff;
      byte_cnt_in   = byte_cnt_ff;
      shift_in      = shift_ff;
      sync_in       = sync_ff;
      data_in       = data_ff;
      index_in      = index_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;

      if (accept) begin
         if (!frame_open_ff) begin
            if (start_hit) begin
               frame_open_in = 1'b1;
               bit_cnt_in    = '0;
               byte_cnt_in   = '0;
               shift_in      = '0;
               sync_in       = 1'b0;
            end
         end else begin
            shift_in   = {shift_ff[BYTE_W-2:0], hit_one};
            sync_in    = sync_ff | (~hit_one & ~hit_zero & hit_sync);
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (byte_done) begin
               rsp_valid_in = 1'b1;
               data_in      = sync_in ? SYNC_BYTE : shift_in;
               index_in     = byte_ext[INDEX_W-1:0];
               last_in      = (byte_cnt_ff == BYTE_LAST);
               shift_in     = '0;
               sync_in      = 1'b0;
               byte_cnt_in  = byte_cnt_ff + 1'b1;
               if (last_in) begin
                  frame_open_in = 1'b0;
                  byte_cnt_in   = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      index_ff <= index_in;
      last_ff  <= last_in;
      shift_ff <= shift_in;
      sync_ff  <= sync_in;
      if (reset) begin
         frame_open_ff <= 1'b0;
         bit_cnt_ff    <= '0;
         byte_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         start_min_ff  <= START_MIN_RST;
         start_max_ff  <= START_MAX_RST;
         one_min_ff    <= ONE_MIN_RST;
         one_max_ff    <= ONE_MAX_RST;
         zero_min_ff   <= ZERO_MIN_RST;
         zero_max_ff   <= ZERO_MAX_RST;
         sync_min_ff   <= SYNC_MIN_RST;
         sync_max_ff   <= SYNC_MAX_RST;
      end else begin
         frame_open_ff <= frame_open_in;
         bit_cnt_ff    <= bit_cnt_in;
         byte_cnt_ff   <= byte_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_START_MIN: start_min_ff <= csr_wdata;
               REG_START_MAX: start_max_ff <= csr_wdata;
               REG_ONE_MIN:   one_min_ff   <= csr_wdata;
               REG_ONE_MAX:   one_max_ff   <= csr_wdata;
               REG_ZERO_MIN:  zero_min_ff  <= csr_wdata;
               REG_ZERO_MAX:  zero_max_ff  <= csr_wdata;
               REG_SYNC_MIN:  sync_min_ff  <= csr_wdata;
               REG_SYNC_MAX:  sync_max_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_byte_index = index_ff;
   assign rsp_last_byte  = last_ff;

   `IRPWFD_ASSERT(a_last_closes_frame, clock, reset,
      emit && (byte_cnt_ff == BYTE_LAST) |=> !frame_open_ff && rsp_last_byte,
      "last byte did not close the frame")
   `IRPWFD_ASSERT_ALWAYS(a_idle_counters_clear, clock,
      !frame_open_ff && !$past(reset) |-> bit_cnt_ff == '0 && byte_cnt_ff == '0,
      "counters not clear while idle")
   `IRPWFD_ASSERT(a_byte_end_emits, clock, reset,
      emit |=> rsp_valid,
      "byte end produced no transaction")
   `IRPWFD_ASSERT(a_held_result_stalls_input, clock, reset,
      rsp_valid && rsp_stall |-> req_stall,
      "input taken while result held")

endmodule

`default_nettype wire
